// ===== src/sfe_pkg.sv =====
// ----------------------------------------------------------------------------
// sfe_pkg
// types and widths shared by the spring force pipeline
// ----------------------------------------------------------------------------
package sfe_pkg;

  localparam int MAG_W    = 33;
  localparam int SUM_W    = 66;
  localparam int RAD_W    = 68;
  localparam int ROOT_W   = 34;
  localparam int REM_W    = 37;
  localparam int SQRT_N   = 34;
  localparam int SCALE_W  = 64;
  localparam int NUM_W    = 97;
  localparam int DEN_W    = 50;
  localparam int QUO_W    = 32;
  localparam int LANES    = 3;

  localparam logic [31:0] FORCE_MAX = 32'h7fff_ffff;
  localparam logic [31:0] FORCE_MIN = 32'h8000_0000;

  typedef struct packed {
    logic signed [31:0] first_x;
    logic signed [31:0] first_y;
    logic signed [31:0] first_z;
    logic signed [31:0] second_x;
    logic signed [31:0] second_y;
    logic signed [31:0] second_z;
    logic [30:0]        spring_stiffness;
    logic [30:0]        rest_length;
  } spring_t;

  typedef struct packed {
    logic signed [31:0] force_x;
    logic signed [31:0] force_y;
    logic signed [31:0] force_z;
    logic               zero_length;
    logic               saturated;
  } force_t;

  typedef struct packed {
    logic [LANES-1:0][MAG_W-1:0] mag;
    logic [LANES-1:0]            neg;
    logic [30:0]                 k;
    logic [30:0]                 rest;
  } sqrt_side_t;

  typedef struct packed {
    logic [LANES-1:0] neg;
    logic [LANES-1:0] ovf;
    logic             shrink;
    logic             zero;
  } div_side_t;

endpackage

// ===== src/spring_force_evaluator_core.sv =====
// ----------------------------------------------------------------------------
// spring_force_evaluator_core
// hooke spring force on one 3d spring per cycle, q16.16 fixed point
// ----------------------------------------------------------------------------
//  channel   ports                 transfer
//  input     start, busy, spring   start high while busy low
//  output    done, result          done high, one cycle, no back pressure
//
//  one spring is taken every cycle; busy is always low
//  the pipeline has 34 square root stages, 32 divide stages and 9 others
//  the square root and divider advance one bit per stage
//  reset clears the valid bits only; items in flight are dropped
// ----------------------------------------------------------------------------
module spring_force_evaluator_core (
  input  logic             clk,
  input  logic             rst,
  input  logic             start,
  output logic             busy,
  input  sfe_pkg::spring_t spring,
  output logic             done,
  output sfe_pkg::force_t  result
);

  localparam int L = sfe_pkg::LANES;

  logic signed [31:0] fa [0:L-1];
  logic signed [31:0] fb [0:L-1];

  assign fa[0] = spring.first_x;
  assign fa[1] = spring.first_y;
  assign fa[2] = spring.first_z;
  assign fb[0] = spring.second_x;
  assign fb[1] = spring.second_y;
  assign fb[2] = spring.second_z;

  assign busy = 1'b0;

  // stage 1: difference vector
  logic                                  v1;
  logic [L-1:0][sfe_pkg::MAG_W-1:0]      mag1;
  logic [L-1:0]                          neg1;
  logic [30:0]                           k1;
  logic [30:0]                           rest1;

  // stage 2: squares
  logic                                  v2;
  logic [L-1:0][sfe_pkg::SUM_W-1:0]      sq2;
  logic [L-1:0][sfe_pkg::MAG_W-1:0]      mag2;
  logic [L-1:0]                          neg2;
  logic [30:0]                           k2;
  logic [30:0]                           rest2;

  // stage 3: sum of squares
  logic                                  v3;
  logic [sfe_pkg::SUM_W-1:0]             sum3;
  sfe_pkg::sqrt_side_t                   side3;

  logic                                  vs;
  logic [sfe_pkg::ROOT_W-1:0]            len_s;
  sfe_pkg::sqrt_side_t                   side_s;

  // stage 4: length minus rest
  logic                                  v4;
  logic [L-1:0][sfe_pkg::MAG_W-1:0]      mag4;
  logic [L-1:0]                          neg4;
  logic [30:0]                           k4;
  logic [sfe_pkg::ROOT_W-1:0]            diff4;
  logic                                  shrink4;
  logic                                  zero4;
  logic [sfe_pkg::DEN_W-1:0]             den4;

  // stage 5: stiffness times stretch
  logic                                  v5;
  logic [L-1:0][sfe_pkg::MAG_W-1:0]      mag5;
  logic [L-1:0]                          neg5;
  logic [sfe_pkg::SCALE_W-1:0]           scale5;
  logic                                  shrink5;
  logic                                  zero5;
  logic [sfe_pkg::DEN_W-1:0]             den5;

  // stage 6: partial products
  logic                                  v6;
  logic [L-1:0][64:0]                    plo6;
  logic [L-1:0][64:0]                    phi6;
  logic [L-1:0]                          neg6;
  logic                                  shrink6;
  logic                                  zero6;
  logic [sfe_pkg::DEN_W-1:0]             den6;

  // stage 7: numerators
  logic                                  v7;
  logic [L-1:0][sfe_pkg::NUM_W-1:0]      num7;
  logic [L-1:0]                          neg7;
  logic                                  shrink7;
  logic                                  zero7;
  logic [sfe_pkg::DEN_W-1:0]             den7;

  // stage 8: overflow check
  logic                                  v8;
  logic [L-1:0][sfe_pkg::NUM_W-1:0]      num8;
  logic [sfe_pkg::DEN_W-1:0]             den8;
  sfe_pkg::div_side_t                    side8;

  logic                                  vd;
  logic [L-1:0][sfe_pkg::QUO_W-1:0]      quo_d;
  sfe_pkg::div_side_t                    side_d;

  logic [L-1:0][31:0]                    frc;
  logic [L-1:0]                          sat;

  always_ff @(posedge clk) begin
    if (rst) begin
      v1   <= 1'b0;
      v2   <= 1'b0;
      v3   <= 1'b0;
      v4   <= 1'b0;
      v5   <= 1'b0;
      v6   <= 1'b0;
      v7   <= 1'b0;
      v8   <= 1'b0;
      done <= 1'b0;
    end else begin
      v1   <= start && !busy;
      v2   <= v1;
      v3   <= v2;
      v4   <= vs;
      v5   <= v4;
      v6   <= v5;
      v7   <= v6;
      v8   <= v7;
      done <= vd;
    end
  end

  always_ff @(posedge clk) begin
    for (int i = 0; i < L; i++) begin
      logic signed [32:0] d;
      d       = {fa[i][31], fa[i]} - {fb[i][31], fb[i]};
      neg1[i] <= d[32];
      mag1[i] <= d[32] ? 33'(-d) : 33'(d);
    end
    k1    <= spring.spring_stiffness;
    rest1 <= spring.rest_length;
  end

  always_ff @(posedge clk) begin
    for (int i = 0; i < L; i++) begin
      sq2[i] <= {33'b0, mag1[i]} * {33'b0, mag1[i]};
    end
    mag2  <= mag1;
    neg2  <= neg1;
    k2    <= k1;
    rest2 <= rest1;
  end

  always_ff @(posedge clk) begin
    sum3       <= sq2[0] + sq2[1] + sq2[2];
    side3.mag  <= mag2;
    side3.neg  <= neg2;
    side3.k    <= k2;
    side3.rest <= rest2;
  end

  sfe_isqrt u_isqrt (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (v3),
    .radicand  (sum3),
    .in_side   (side3),
    .out_valid (vs),
    .root_out  (len_s),
    .out_side  (side_s)
  );

  always_ff @(posedge clk) begin
    logic [sfe_pkg::ROOT_W-1:0] rst_len;
    rst_len = {3'b0, side_s.rest};
    mag4    <= side_s.mag;
    neg4    <= side_s.neg;
    k4      <= side_s.k;
    shrink4 <= len_s < rst_len;
    diff4   <= (len_s < rst_len) ? rst_len - len_s : len_s - rst_len;
    zero4   <= len_s == '0;
    den4    <= {len_s, 16'b0};
  end

  always_ff @(posedge clk) begin
    logic [64:0] prod;
    prod    = {34'b0, k4} * {31'b0, diff4};
    scale5  <= prod[sfe_pkg::SCALE_W-1:0];
    mag5    <= mag4;
    neg5    <= neg4;
    shrink5 <= shrink4;
    zero5   <= zero4;
    den5    <= den4;
  end

  always_ff @(posedge clk) begin
    for (int i = 0; i < L; i++) begin
      plo6[i] <= {33'b0, scale5[31:0]} * {32'b0, mag5[i]};
      phi6[i] <= {33'b0, scale5[63:32]} * {32'b0, mag5[i]};
    end
    neg6    <= neg5;
    shrink6 <= shrink5;
    zero6   <= zero5;
    den6    <= den5;
  end

  always_ff @(posedge clk) begin
    for (int i = 0; i < L; i++) begin
      num7[i] <= {32'b0, plo6[i]} + {phi6[i], 32'b0};
    end
    neg7    <= neg6;
    shrink7 <= shrink6;
    zero7   <= zero6;
    den7    <= den6;
  end

  always_ff @(posedge clk) begin
    for (int i = 0; i < L; i++) begin
      side8.ovf[i] <= num7[i][sfe_pkg::NUM_W-1:32] >= {15'b0, den7};
    end
    num8         <= num7;
    den8         <= den7;
    side8.neg    <= neg7;
    side8.shrink <= shrink7;
    side8.zero   <= zero7;
  end

  sfe_divider u_divider (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (v8),
    .num       (num8),
    .denom     (den8),
    .in_side   (side8),
    .out_valid (vd),
    .quo_out   (quo_d),
    .out_side  (side_d)
  );

  always_comb begin
    for (int i = 0; i < L; i++) begin
      frc[i] = '0;
      sat[i] = 1'b0;
      if (side_d.zero) begin
        frc[i] = '0;
      end else if ((side_d.shrink != side_d.neg[i]) &&
                   (side_d.ovf[i] || quo_d[i] != '0)) begin
        if (side_d.ovf[i] || quo_d[i] > sfe_pkg::FORCE_MIN) begin
          frc[i] = sfe_pkg::FORCE_MIN;
          sat[i] = 1'b1;
        end else begin
          frc[i] = -quo_d[i];
        end
      end else begin
        if (side_d.ovf[i] || quo_d[i][31]) begin
          frc[i] = sfe_pkg::FORCE_MAX;
          sat[i] = 1'b1;
        end else begin
          frc[i] = quo_d[i];
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    result.force_x     <= frc[0];
    result.force_y     <= frc[1];
    result.force_z     <= frc[2];
    result.zero_length <= side_d.zero;
    result.saturated   <= |sat;
  end

endmodule

// ===== src/sfe_isqrt.sv =====
// ----------------------------------------------------------------------------
// sfe_isqrt
// pipelined integer square root, one root bit per stage
// ----------------------------------------------------------------------------
module sfe_isqrt (
  input  logic                                clk,
  input  logic                                rst,
  input  logic                                in_valid,
  input  logic [sfe_pkg::SUM_W-1:0]           radicand,
  input  sfe_pkg::sqrt_side_t                 in_side,
  output logic                                out_valid,
  output logic [sfe_pkg::ROOT_W-1:0]          root_out,
  output sfe_pkg::sqrt_side_t                 out_side
);

  logic [sfe_pkg::SQRT_N:0]     vld;
  logic [sfe_pkg::RAD_W-1:0]    rad  [0:sfe_pkg::SQRT_N];
  logic [sfe_pkg::REM_W-1:0]    rem  [0:sfe_pkg::SQRT_N];
  logic [sfe_pkg::ROOT_W-1:0]   root [0:sfe_pkg::SQRT_N];
  sfe_pkg::sqrt_side_t          side [0:sfe_pkg::SQRT_N];

  assign vld[0]  = in_valid;
  assign rad[0]  = {{(sfe_pkg::RAD_W - sfe_pkg::SUM_W){1'b0}}, radicand};
  assign rem[0]  = '0;
  assign root[0] = '0;
  assign side[0] = in_side;

  genvar g;
  for (g = 0; g < sfe_pkg::SQRT_N; g++) begin : g_stage
    logic [sfe_pkg::REM_W-1:0] acc;
    logic [sfe_pkg::REM_W-1:0] trial;

    assign acc   = {rem[g][sfe_pkg::REM_W-3:0], rad[g][sfe_pkg::RAD_W-1 -: 2]};
    assign trial = {1'b0, root[g], 2'b01};

    always_ff @(posedge clk) begin
      if (rst) begin
        vld[g+1] <= 1'b0;
      end else begin
        vld[g+1] <= vld[g];
      end
    end

    always_ff @(posedge clk) begin
      rad[g+1]  <= rad[g] << 2;
      side[g+1] <= side[g];
      if (acc >= trial) begin
        rem[g+1]  <= acc - trial;
        root[g+1] <= {root[g][sfe_pkg::ROOT_W-2:0], 1'b1};
      end else begin
        rem[g+1]  <= acc;
        root[g+1] <= {root[g][sfe_pkg::ROOT_W-2:0], 1'b0};
      end
    end
  end

  assign out_valid = vld[sfe_pkg::SQRT_N];
  assign root_out  = root[sfe_pkg::SQRT_N];
  assign out_side  = side[sfe_pkg::SQRT_N];

endmodule

// ===== src/sfe_divider.sv =====
// ----------------------------------------------------------------------------
// sfe_divider
// pipelined restoring divider, three lanes sharing one divisor
// ----------------------------------------------------------------------------
module sfe_divider (
  input  logic                                                  clk,
  input  logic                                                  rst,
  input  logic                                                  in_valid,
  input  logic [sfe_pkg::LANES-1:0][sfe_pkg::NUM_W-1:0]         num,
  input  logic [sfe_pkg::DEN_W-1:0]                             denom,
  input  sfe_pkg::div_side_t                                    in_side,
  output logic                                                  out_valid,
  output logic [sfe_pkg::LANES-1:0][sfe_pkg::QUO_W-1:0]         quo_out,
  output sfe_pkg::div_side_t                                    out_side
);

  localparam int N = sfe_pkg::QUO_W;
  localparam int D = sfe_pkg::DEN_W;
  localparam int L = sfe_pkg::LANES;

  logic [N:0]             vld;
  logic [L-1:0][D-1:0]    rmd  [0:N];
  logic [L-1:0][N-1:0]    low  [0:N];
  logic [L-1:0][N-1:0]    quo  [0:N];
  logic [D-1:0]           den  [0:N];
  sfe_pkg::div_side_t     side [0:N];

  assign vld[0]  = in_valid;
  assign den[0]  = denom;
  assign side[0] = in_side;
  assign quo[0]  = '0;

  genvar l;
  for (l = 0; l < L; l++) begin : g_init
    assign rmd[0][l] = num[l][N+D-1:N];
    assign low[0][l] = num[l][N-1:0];
  end

  genvar g;
  for (g = 0; g < N; g++) begin : g_stage
    always_ff @(posedge clk) begin
      if (rst) begin
        vld[g+1] <= 1'b0;
      end else begin
        vld[g+1] <= vld[g];
      end
    end

    always_ff @(posedge clk) begin
      den[g+1]  <= den[g];
      side[g+1] <= side[g];
    end

    for (l = 0; l < L; l++) begin : g_lane
      logic [D:0] part;
      logic [D:0] diff;

      assign part = {rmd[g][l], low[g][l][N-1]};
      assign diff = part - {1'b0, den[g]};

      always_ff @(posedge clk) begin
        low[g+1][l] <= low[g][l] << 1;
        if (part >= {1'b0, den[g]}) begin
          rmd[g+1][l] <= diff[D-1:0];
          quo[g+1][l] <= {quo[g][l][N-2:0], 1'b1};
        end else begin
          rmd[g+1][l] <= part[D-1:0];
          quo[g+1][l] <= {quo[g][l][N-2:0], 1'b0};
        end
      end
    end
  end

  assign out_valid = vld[N];
  assign quo_out   = quo[N];
  assign out_side  = side[N];

endmodule

// ===== sim/spring_force_checker.sv =====
// ----------------------------------------------------------------------------
// spring_force_checker
// watches the spring and force channels, predicts each force with exact
// wide integer arithmetic and compares results in order
// ----------------------------------------------------------------------------
module spring_force_checker (
  input  logic             clk,
  input  logic             rst,
  input  logic             start,
  input  logic             busy,
  input  sfe_pkg::spring_t spring,
  input  logic             done,
  input  sfe_pkg::force_t  result,
  output int               fail_count,
  output int               pending
);
  timeunit 1ns;
  timeprecision 1ps;

  sfe_pkg::force_t expected_forces[$];

  function automatic sfe_pkg::force_t hooke_force(sfe_pkg::spring_t s);
    sfe_pkg::force_t f;
    logic signed [32:0] d[3];
    logic [32:0] m[3];
    logic [67:0] sumsq;
    logic [33:0] len, cand;
    logic [67:0] sq;
    logic [33:0] stretch;
    logic [63:0] scale;
    logic [49:0] denom;
    logic [127:0] quo;
    logic [31:0] comp[3];
    logic shrink, neg;
    d[0] = 33'(s.first_x) - 33'(s.second_x);
    d[1] = 33'(s.first_y) - 33'(s.second_y);
    d[2] = 33'(s.first_z) - 33'(s.second_z);
    sumsq = '0;
    for (int i = 0; i < 3; i++) begin
      m[i] = d[i][32] ? 33'(-d[i]) : 33'(d[i]);
      sumsq += 68'(m[i]) * 68'(m[i]);
    end
    len = '0;
    for (int b = 33; b >= 0; b--) begin
      cand = len | (34'd1 << b);
      sq = 68'(cand) * 68'(cand);
      if (sq <= sumsq) len = cand;
    end
    f = '0;
    if (len == 0) begin
      f.zero_length = 1'b1;
      return f;
    end
    shrink = len < 34'(s.rest_length);
    stretch = shrink ? 34'(s.rest_length) - len : len - 34'(s.rest_length);
    scale = 64'(s.spring_stiffness) * 64'(stretch);
    denom = 50'(len) << 16;
    for (int i = 0; i < 3; i++) begin
      quo = (128'(scale) * 128'(m[i])) / 128'(denom);
      neg = (shrink != d[i][32]) && (quo != 0);
      if (neg) begin
        if (quo > 128'h8000_0000) begin
          comp[i] = sfe_pkg::FORCE_MIN;
          f.saturated = 1'b1;
        end else begin
          comp[i] = 32'(-quo);
        end
      end else if (quo > 128'h7fff_ffff) begin
        comp[i] = sfe_pkg::FORCE_MAX;
        f.saturated = 1'b1;
      end else begin
        comp[i] = quo[31:0];
      end
    end
    f.force_x = comp[0];
    f.force_y = comp[1];
    f.force_z = comp[2];
    return f;
  endfunction

  assign pending = expected_forces.size();

  always @(posedge clk) begin
    sfe_pkg::force_t want;
    int errs;
    errs = 0;
    if (rst) begin
      fail_count <= 0;
    end else begin
      if (start && !busy) expected_forces.push_back(hooke_force(spring));
      if (done) begin
        if (expected_forces.size() == 0) begin
          $error("force result with none expected");
          errs++;
        end else begin
          want = expected_forces.pop_front();
          if (result.force_x !== want.force_x) begin
            $error("force_x expected %h got %h", want.force_x, result.force_x);
            errs++;
          end
          if (result.force_y !== want.force_y) begin
            $error("force_y expected %h got %h", want.force_y, result.force_y);
            errs++;
          end
          if (result.force_z !== want.force_z) begin
            $error("force_z expected %h got %h", want.force_z, result.force_z);
            errs++;
          end
          if (result.zero_length !== want.zero_length) begin
            $error("zero_length expected %b got %b", want.zero_length, result.zero_length);
            errs++;
          end
          if (result.saturated !== want.saturated) begin
            $error("saturated expected %b got %b", want.saturated, result.saturated);
            errs++;
          end
        end
      end
      fail_count <= fail_count + errs;
    end
  end
endmodule

// ===== sim/tb.sv =====
// ----------------------------------------------------------------------------
// tb
// spring force regression: directed corner springs, then random springs of
// mixed scale, with random sender gaps and full drains after the directed
// springs, after random spring 900 and at the end
module tb;
  timeunit 1ns;
  timeprecision 1ps;

  logic clk = 1'b0;
  logic rst = 1'b1;
  logic start = 1'b0;
  logic busy, done;
  sfe_pkg::spring_t spring = '0;
  sfe_pkg::force_t result;
  int fail_count, pending;

  spring_force_evaluator_core dut (
    .clk(clk), .rst(rst), .start(start), .busy(busy),
    .spring(spring), .done(done), .result(result)
  );

  spring_force_checker chk (
    .clk(clk), .rst(rst), .start(start), .busy(busy), .spring(spring),
    .done(done), .result(result), .fail_count(fail_count), .pending(pending)
  );

  always #10 clk = ~clk;

  initial begin
    #5ms;
    $display("[FAIL] regression broken");
    $finish;
  end

  function automatic logic [31:0] rand_coord(int scale);
    case (scale)
      0: return 32'($signed($urandom_range(0, 2048)) - 1024);
      1: return 32'($signed($urandom_range(0, 32'h0020_0000)) - 32'h0010_0000);
      2: return 32'($urandom_range(0, 7)) ^ 32'h8000_0000;
      default: return $urandom;
    endcase
  endfunction

  task automatic send_spring(sfe_pkg::spring_t s, bit gaps);
    spring <= s;
    start <= 1'b1;
    @(posedge clk);
    while (busy) @(posedge clk);
    if (gaps) begin
      while ($urandom_range(0, 99) < 24) begin
        start <= 1'b0;
        @(posedge clk);
      end
    end
  endtask

  initial begin
    sfe_pkg::spring_t s;
    int scale;
    repeat (9) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);
    s = '0;
    send_spring(s, 0);
    s.spring_stiffness = '1; s.rest_length = '1;
    send_spring(s, 0);
    s = '0; s.first_x = 32'sh7fff_ffff; s.second_x = 32'sh8000_0000;
    s.first_y = 32'sh8000_0000; s.second_y = 32'sh7fff_ffff;
    s.first_z = 32'sh7fff_ffff; s.second_z = 32'sh8000_0000;
    s.spring_stiffness = '1;
    send_spring(s, 0);
    s.rest_length = '1;
    send_spring(s, 0);
    s.spring_stiffness = '0;
    send_spring(s, 0);
    s = '0; s.first_x = 32'h0001_0000; s.spring_stiffness = 31'h0001_0000;
    s.rest_length = 31'h0002_0000;
    send_spring(s, 0);
    s.rest_length = 31'h0001_0000;
    send_spring(s, 0);
    s = '0; s.second_z = 32'd1; s.spring_stiffness = '1;
    send_spring(s, 0);
    s.first_y = 32'd3; s.second_z = 32'd4; s.rest_length = 31'd5;
    send_spring(s, 0);
    s = '0; s.first_x = 32'sh8000_0000; s.first_y = 32'sh8000_0000;
    s.first_z = 32'sh8000_0000; s.spring_stiffness = 31'h0000_0001;
    send_spring(s, 0);
    start <= 1'b0;
    while (pending != 0) @(posedge clk);
    for (int n = 0; n < 1400; n++) begin
      scale = $urandom_range(0, 3);
      s.first_x = rand_coord(scale); s.first_y = rand_coord(scale);
      s.first_z = rand_coord(scale);
      s.second_x = rand_coord(scale); s.second_y = rand_coord(scale);
      s.second_z = rand_coord(scale);
      if ($urandom_range(0, 19) == 0) begin
        s.second_x = s.first_x; s.second_y = s.first_y; s.second_z = s.first_z;
      end
      s.spring_stiffness = ($urandom_range(0, 3) == 0) ? 31'($urandom)
                         : 31'($urandom_range(0, 32'h0004_0000));
      s.rest_length = ($urandom_range(0, 3) == 0) ? 31'($urandom)
                    : 31'($urandom_range(0, 32'h0040_0000));
      send_spring(s, !(n >= 500 && n < 700));
      if (n == 900) begin
        start <= 1'b0;
        while (pending != 0) @(posedge clk);
      end
    end
    start <= 1'b0;
    while (pending != 0) @(posedge clk);
    repeat (100) @(posedge clk);
    if (fail_count == 0 && pending == 0) begin
      $display("[ OK ] regression clean");
    end else begin
      $display("[FAIL] regression broken");
    end
    $finish;
  end
endmodule
